// ----- rtl/calendar_to_epoch_seconds_assert.svh -----
// assertion macros for the calendar to epoch seconds block
`ifndef CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH
`define CALENDAR_TO_EPOCH_SECONDS_ASSERT_SVH

// plain property, clocked on clk_i, off during reset
`define C2E_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// overlapping implication, clocked on clk_i, off during reset
`define C2E_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- rtl/c2e_pkg.sv -----
// types, constants and table functions of the calendar to epoch seconds block
package c2e_pkg;

  localparam int unsigned YearW   = 14;
  localparam int unsigned FieldW  = 7;
  localparam int unsigned MilliW  = 10;
  localparam int unsigned EpochW  = 39;
  localparam int unsigned DaysW   = 24;
  localparam int unsigned HmsW    = 17;
  localparam int unsigned ProdW   = 41;
  localparam int unsigned SumW    = 42;

  localparam logic [YearW-1:0]   YearMin    = 14'd1950;
  localparam logic [MilliW-1:0]  MilliPerSec = 10'd1000;
  localparam logic [16:0]        MinuteMs   = 17'd60000;
  localparam logic signed [DaysW-1:0] DayBias = 24'sd719468;
  localparam logic signed [17:0] SecPerDay  = 18'sd86400;
  localparam logic signed [SumW-1:0] SecMax = 42'sd274877906943;

  // floor(x / 25) for x < 4096 by reciprocal multiply
  localparam logic [12:0] Div25Mul = 13'd5243;
  localparam int unsigned Div25Sh  = 17;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_ZERO   = 3'd1,
    ST_EARLY  = 3'd2,
    ST_HOUR   = 3'd3,
    ST_MINUTE = 3'd4,
    ST_SECOND = 3'd5,
    ST_DATE   = 3'd6
  } status_e;

  typedef struct packed {
    logic [YearW-1:0]  year_in;
    logic [FieldW-1:0] month_in;
    logic [FieldW-1:0] day_in;
    logic [FieldW-1:0] hour_in;
    logic [FieldW-1:0] minute_in;
    logic [FieldW-1:0] second_in;
    logic [MilliW-1:0] milli_in;
  } in_item_t;

  typedef struct packed {
    logic signed [EpochW-1:0] epoch_seconds;
    logic [MilliW-1:0]        milli_out;
    status_e                  status;
  } out_item_t;

  typedef struct packed {
    status_e           status;
    logic [YearW-1:0]  year;
    logic [YearW-1:0]  yy;
    logic [3:0]        month;
    logic [FieldW-1:0] day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [5:0]        sec;
    logic [MilliW-1:0] milli;
    logic [7:0]        q_y100;
    logic [7:0]        q_y400;
    logic [7:0]        q_yy100;
    logic [7:0]        q_yy400;
  } s1_t;

  typedef struct packed {
    status_e                 status;
    logic signed [DaysW-1:0] days;
    logic [HmsW-1:0]         hms;
    logic [MilliW-1:0]       milli;
  } s2_t;

  function automatic logic [7:0] div25(input logic [11:0] x);
    logic [24:0] p;
    p = 25'(x) * 25'(Div25Mul);
    return p[24:Div25Sh];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days from march 1 to the first of the month, year starting in march
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] off;
    case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

// ----- rtl/c2e_stage2.sv -----
// second stage logic: leap rule, day check, day count and time of day
module c2e_stage2 (
  input  c2e_pkg::s1_t s1_i,
  output c2e_pkg::s2_t s2_o
);

  logic        div100;
  logic        div400;
  logic        leap;
  logic [4:0]  mlen;
  logic [8:0]  offset;
  logic [22:0] doy;
  logic [22:0] day_sum;

  assign div100 = (s1_i.year[1:0] == 2'd0) &&
                  (s1_i.year[13:2] == 12'(s1_i.q_y100) * 12'd25);
  assign div400 = (s1_i.year[3:0] == 4'd0) &&
                  (12'(s1_i.year[13:4]) == 12'(s1_i.q_y400) * 12'd25);
  assign leap   = ((s1_i.year[1:0] == 2'd0) && !div100) || div400;

  assign mlen   = c2e_pkg::month_len(s1_i.month, leap);
  assign offset = c2e_pkg::month_offset(s1_i.month);
  assign doy    = 23'(offset) + 23'(s1_i.day) - 23'd1;

  // days since march 1 of year zero
  assign day_sum = 23'(s1_i.yy) * 23'd365 + 23'(s1_i.yy[13:2]) - 23'(s1_i.q_yy100)
                 + 23'(s1_i.q_yy400) + doy;

  always_comb begin
    s2_o.status = s1_i.status;
    if (s1_i.status == c2e_pkg::ST_OK && s1_i.day > 7'(mlen)) begin
      s2_o.status = c2e_pkg::ST_DATE;
    end
    s2_o.days  = $signed({1'b0, day_sum}) - c2e_pkg::DayBias;
    s2_o.hms   = 17'(s1_i.hour) * 17'd3600 + 17'(s1_i.minute) * 17'd60 + 17'(s1_i.sec);
    s2_o.milli = s1_i.milli;
  end

endmodule

// ----- rtl/calendar_to_epoch_seconds.sv -----
// Gregorian date and time to signed Unix seconds, four stage pipeline
//
// Input channel in_valid_i / in_ready_o carries one date and time item in
// in_item_i. Output channel out_valid_o / out_ready_i carries one result item
// in out_item_o: epoch seconds, millisecond part and a status code. Every
// input item gives exactly one result, in order.
// An accepted item moves through the s1, s2 and s3 registers to the output
// register; one item can be accepted in every cycle while the output is not
// stalled. The stages are field checks with the divide-by-25 multiplies, the
// leap rule and day count, the day by 86400 multiply, and the final add with
// saturation.
// Each stage holds a valid bit; a stage takes a new item when it is empty or
// its successor moves on, so bubbles close up and a stalled receiver holds
// items in place without loss or repetition.
// Reset clears all valid bits; the data registers are not reset. An item with a
// nonzero status gives zero seconds and zero milliseconds.
`include "calendar_to_epoch_seconds_assert.svh"

module calendar_to_epoch_seconds (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  c2e_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output c2e_pkg::out_item_t   out_item_o
);

  logic s1_valid_q, s2_valid_q, s3_valid_q, out_valid_q;
  logic ready1, ready2, ready3, ready4;

  c2e_pkg::s1_t      s1_d, s1_q;
  c2e_pkg::s2_t      s2_d, s2_q;
  c2e_pkg::s2_t      s3_d;
  c2e_pkg::status_e  s3_status_q;
  logic signed [c2e_pkg::ProdW-1:0] s3_prod_q;
  logic [c2e_pkg::HmsW-1:0]         s3_hms_q;
  logic [c2e_pkg::MilliW-1:0]       s3_milli_q;
  c2e_pkg::out_item_t out_d, out_q;

  logic [16:0]                t_ms;
  logic                       milli_carry;
  logic                       m_le2;
  logic [c2e_pkg::YearW-1:0]  yy;
  logic [c2e_pkg::FieldW-1:0] sec_whole;
  logic signed [c2e_pkg::SumW-1:0] sec_sum;

  logic s3_stall;
  logic out_ok;
  logic out_zero;
  logic out_in_range;

  assign ready4     = !out_valid_q || out_ready_i;
  assign ready3     = !s3_valid_q || ready4;
  assign ready2     = !s2_valid_q || ready3;
  assign ready1     = !s1_valid_q || ready2;
  assign in_ready_o = ready1;

  // stage 1: field checks and reciprocal divides
  assign t_ms        = 17'(in_item_i.second_in) * 17'd1000 + 17'(in_item_i.milli_in);
  assign milli_carry = in_item_i.milli_in >= c2e_pkg::MilliPerSec;
  assign m_le2       = in_item_i.month_in <= 7'd2;
  assign yy          = in_item_i.year_in - c2e_pkg::YearW'(m_le2);
  assign sec_whole   = in_item_i.second_in + c2e_pkg::FieldW'(milli_carry);

  always_comb begin
    if (in_item_i.year_in == '0 || in_item_i.month_in == '0 || in_item_i.day_in == '0) begin
      s1_d.status = c2e_pkg::ST_ZERO;
    end else if (in_item_i.year_in < c2e_pkg::YearMin) begin
      s1_d.status = c2e_pkg::ST_EARLY;
    end else if (in_item_i.hour_in > 7'd23) begin
      s1_d.status = c2e_pkg::ST_HOUR;
    end else if (in_item_i.minute_in > 7'd59) begin
      s1_d.status = c2e_pkg::ST_MINUTE;
    end else if (t_ms >= c2e_pkg::MinuteMs) begin
      s1_d.status = c2e_pkg::ST_SECOND;
    end else if (in_item_i.month_in > 7'd12) begin
      s1_d.status = c2e_pkg::ST_DATE;
    end else begin
      s1_d.status = c2e_pkg::ST_OK;
    end
    s1_d.year    = in_item_i.year_in;
    s1_d.yy      = yy;
    s1_d.month   = in_item_i.month_in[3:0];
    s1_d.day     = in_item_i.day_in;
    s1_d.hour    = in_item_i.hour_in[4:0];
    s1_d.minute  = in_item_i.minute_in[5:0];
    s1_d.sec     = sec_whole[5:0];
    s1_d.milli   = milli_carry ? in_item_i.milli_in - c2e_pkg::MilliPerSec
                               : in_item_i.milli_in;
    s1_d.q_y100  = c2e_pkg::div25(in_item_i.year_in[13:2]);
    s1_d.q_y400  = c2e_pkg::div25(12'(in_item_i.year_in[13:4]));
    s1_d.q_yy100 = c2e_pkg::div25(yy[13:2]);
    s1_d.q_yy400 = c2e_pkg::div25(12'(yy[13:4]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (ready1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1 && in_valid_i) begin
      s1_q <= s1_d;
    end
  end

  // stage 2: leap rule, day check, day count and time of day
  c2e_stage2 u_stage2 (
    .s1_i (s1_q),
    .s2_o (s2_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (ready2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready2 && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  // stage 3: days to seconds
  assign s3_d = s2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (ready3) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready3 && s2_valid_q) begin
      s3_status_q <= s3_d.status;
      s3_prod_q   <= c2e_pkg::ProdW'(s3_d.days) * c2e_pkg::ProdW'(c2e_pkg::SecPerDay);
      s3_hms_q    <= s3_d.hms;
      s3_milli_q  <= s3_d.milli;
    end
  end

  // stage 4: add time of day, saturate, zero invalid items
  assign sec_sum = {s3_prod_q[c2e_pkg::ProdW-1], s3_prod_q}
                 + $signed(c2e_pkg::SumW'(s3_hms_q));

  always_comb begin
    out_d.status = s3_status_q;
    if (s3_status_q != c2e_pkg::ST_OK) begin
      out_d.epoch_seconds = '0;
      out_d.milli_out     = '0;
    end else begin
      out_d.milli_out = s3_milli_q;
      if (sec_sum > c2e_pkg::SecMax) begin
        out_d.epoch_seconds = c2e_pkg::SecMax[c2e_pkg::EpochW-1:0];
      end else begin
        out_d.epoch_seconds = sec_sum[c2e_pkg::EpochW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ready4) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready4 && s3_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign s3_stall     = s3_valid_q && !ready3;
  assign out_ok       = out_item_o.status == c2e_pkg::ST_OK;
  assign out_zero     = out_item_o.epoch_seconds == '0 && out_item_o.milli_out == '0;
  assign out_in_range = out_item_o.milli_out < c2e_pkg::MilliPerSec &&
                        out_item_o.epoch_seconds >= -39'sd631152000;

  `C2E_ASSERT(a_accept_fills_s1, in_valid_i && in_ready_o |=> s1_valid_q, "accepted item lost")
  `C2E_ASSERT(a_s3_holds, s3_stall |=> s3_valid_q && $stable(s3_prod_q), "stalled s3 item lost")
  `C2E_ASSERT_IMPLIES(a_bad_is_zero, out_valid_o && !out_ok, out_zero, "invalid item not zeroed")
  `C2E_ASSERT_IMPLIES(a_ok_range, out_valid_o && out_ok, out_in_range, "valid result out of range")

endmodule

// ----- tb/calendar_to_epoch_seconds_tb.sv -----
// testbench of the calendar to epoch seconds block: directed dates, random stream, backpressure
`timescale 1ns / 100ps

module calendar_to_epoch_seconds_tb;

  localparam int CycleLimit = 200000;
  localparam longint EpochMax = (longint'(1) << (c2e_pkg::EpochW - 1)) - 1;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  c2e_pkg::in_item_t  in_item_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  c2e_pkg::out_item_t out_item_o;

  c2e_pkg::out_item_t expected_q[$];
  c2e_pkg::out_item_t want;
  int        error_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  int        stall_request = 0;
  int        stall_left = 0;

  calendar_to_epoch_seconds dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int month_days(input logic [c2e_pkg::FieldW-1:0] month,
                                    input logic [c2e_pkg::YearW-1:0] year);
    logic leap;
    int   len;
    leap = ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
    case (month)
      7'd2:                    len = leap ? 29 : 28;
      7'd4, 7'd6, 7'd9, 7'd11: len = 30;
      default:                 len = 31;
    endcase
    return len;
  endfunction

  function automatic c2e_pkg::out_item_t predict_epoch(input c2e_pkg::in_item_t stamp);
    c2e_pkg::out_item_t res;
    longint    t_ms, yy, era, yoe, mp, doy, doe, days, secs;
    res = '0;
    t_ms = longint'(stamp.second_in) * 1000 + longint'(stamp.milli_in);
    if (stamp.year_in == 0 || stamp.month_in == 0 || stamp.day_in == 0) begin
      res.status = c2e_pkg::ST_ZERO;
    end else if (stamp.year_in < c2e_pkg::YearMin) begin
      res.status = c2e_pkg::ST_EARLY;
    end else if (stamp.hour_in > 23) begin
      res.status = c2e_pkg::ST_HOUR;
    end else if (stamp.minute_in > 59) begin
      res.status = c2e_pkg::ST_MINUTE;
    end else if (t_ms >= 60000) begin
      res.status = c2e_pkg::ST_SECOND;
    end else if (stamp.month_in > 12) begin
      res.status = c2e_pkg::ST_DATE;
    end else if (stamp.day_in > month_days(stamp.month_in, stamp.year_in)) begin
      res.status = c2e_pkg::ST_DATE;
    end else begin
      // day count with march-based year, 400-year eras
      yy = longint'(stamp.year_in) - (stamp.month_in <= 2 ? 1 : 0);
      era = yy / 400;
      yoe = yy - era * 400;
      mp = longint'(stamp.month_in) + (stamp.month_in > 2 ? -3 : 9);
      doy = (153 * mp + 2) / 5 + longint'(stamp.day_in) - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = era * 146097 + doe - 719468;
      secs = days * 86400 + longint'(stamp.hour_in) * 3600
           + longint'(stamp.minute_in) * 60 + t_ms / 1000;
      if (secs > EpochMax) secs = EpochMax;
      res.epoch_seconds = secs[c2e_pkg::EpochW-1:0];
      res.milli_out = c2e_pkg::MilliW'(t_ms % 1000);
      res.status = c2e_pkg::ST_OK;
    end
    return res;
  endfunction

  function automatic c2e_pkg::in_item_t make_stamp(input int year, input int month,
                                                   input int day, input int hour,
                                                   input int minute, input int second,
                                                   input int milli);
    c2e_pkg::in_item_t stamp;
    stamp.year_in = c2e_pkg::YearW'(year);
    stamp.month_in = c2e_pkg::FieldW'(month);
    stamp.day_in = c2e_pkg::FieldW'(day);
    stamp.hour_in = c2e_pkg::FieldW'(hour);
    stamp.minute_in = c2e_pkg::FieldW'(minute);
    stamp.second_in = c2e_pkg::FieldW'(second);
    stamp.milli_in = c2e_pkg::MilliW'(milli);
    return stamp;
  endfunction

  function automatic c2e_pkg::in_item_t random_stamp();
    c2e_pkg::in_item_t stamp;
    logic [63:0]       noise;
    int                kind, pick, len;
    kind = $urandom_range(99);
    pick = $urandom_range(9);
    if (pick < 7) stamp.year_in = c2e_pkg::YearW'($urandom_range(2100, 1950));
    else if (pick < 9) stamp.year_in = c2e_pkg::YearW'($urandom_range(9999, 1950));
    else stamp.year_in = c2e_pkg::YearW'($urandom_range(16383, 10000));
    stamp.month_in = c2e_pkg::FieldW'($urandom_range(12, 1));
    len = month_days(stamp.month_in, stamp.year_in);
    if ($urandom_range(3) == 0) stamp.day_in = c2e_pkg::FieldW'(len);
    else stamp.day_in = c2e_pkg::FieldW'($urandom_range(len, 1));
    stamp.hour_in = c2e_pkg::FieldW'($urandom_range(23));
    stamp.minute_in = c2e_pkg::FieldW'($urandom_range(59));
    stamp.second_in = c2e_pkg::FieldW'($urandom_range(59));
    if ($urandom_range(9) == 0 && stamp.second_in <= 58)
      stamp.milli_in = c2e_pkg::MilliW'($urandom_range(1023, 1000));
    else
      stamp.milli_in = c2e_pkg::MilliW'($urandom_range(999));
    if (kind >= 85) begin
      noise = {$urandom(), $urandom()};
      stamp = noise[$bits(c2e_pkg::in_item_t)-1:0];
    end else if (kind >= 70) begin
      case ($urandom_range(6))
        0: stamp.year_in = c2e_pkg::YearW'($urandom_range(1949, 1));
        1: stamp.month_in = c2e_pkg::FieldW'($urandom_range(127, 13));
        2: stamp.day_in = c2e_pkg::FieldW'($urandom_range(127, len + 1));
        3: stamp.hour_in = c2e_pkg::FieldW'($urandom_range(127, 24));
        4: stamp.minute_in = c2e_pkg::FieldW'($urandom_range(127, 60));
        5: begin
          if ($urandom_range(1) == 0) begin
            stamp.second_in = c2e_pkg::FieldW'($urandom_range(127, 60));
          end else begin
            stamp.second_in = 7'd59;
            stamp.milli_in = c2e_pkg::MilliW'($urandom_range(1023, 1000));
          end
        end
        default: begin
          case ($urandom_range(2))
            0: stamp.year_in = '0;
            1: stamp.month_in = '0;
            default: stamp.day_in = '0;
          endcase
        end
      endcase
    end
    return stamp;
  endfunction

  // receiver: random ready, or held low for a requested stretch
  always @(posedge clk_i) begin
    if (stall_request > 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        $error("result item with none expected: epoch_seconds %0d status %0d",
               out_item_o.epoch_seconds, out_item_o.status);
        error_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.epoch_seconds !== want.epoch_seconds) begin
          $error("epoch_seconds: expected %0d, actual %0d",
                 want.epoch_seconds, out_item_o.epoch_seconds);
          error_count++;
        end
        if (out_item_o.milli_out !== want.milli_out) begin
          $error("milli_out: expected %0d, actual %0d", want.milli_out, out_item_o.milli_out);
          error_count++;
        end
        if (out_item_o.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_item_o.status);
          error_count++;
        end
      end
    end
  end

  task automatic send_item(input c2e_pkg::in_item_t stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= stamp;
    do @(posedge clk_i); while (!in_ready_o);
    expected_q.push_back(predict_epoch(stamp));
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_field_extremes();
    send_item(make_stamp(1950, 1, 1, 0, 0, 0, 0));
    send_item(make_stamp(1969, 12, 31, 23, 59, 59, 999));
    send_item(make_stamp(1970, 1, 1, 0, 0, 0, 0));
    send_item(make_stamp(9999, 12, 31, 23, 59, 59, 999));
    send_item(make_stamp(16383, 12, 31, 23, 59, 59, 999));
    send_item(make_stamp(16383, 127, 127, 127, 127, 127, 1023));
    send_item(make_stamp(0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_status_codes();
    send_item(make_stamp(2001, 0, 5, 1, 1, 1, 1));
    send_item(make_stamp(2001, 5, 0, 1, 1, 1, 1));
    send_item(make_stamp(1949, 12, 31, 23, 59, 59, 999));
    send_item(make_stamp(2010, 3, 3, 24, 0, 0, 0));
    send_item(make_stamp(2010, 3, 3, 0, 60, 0, 0));
    send_item(make_stamp(2010, 3, 3, 0, 0, 60, 0));
    send_item(make_stamp(2010, 13, 3, 0, 0, 0, 0));
    send_item(make_stamp(2010, 1, 32, 0, 0, 0, 0));
    send_item(make_stamp(2010, 4, 31, 0, 0, 0, 0));
    send_item(make_stamp(2023, 2, 29, 0, 0, 0, 0));
    send_item(make_stamp(2024, 2, 29, 12, 0, 0, 0));
    send_item(make_stamp(2100, 2, 29, 0, 0, 0, 0));
    send_item(make_stamp(2000, 2, 29, 0, 0, 0, 0));
  endtask

  task automatic test_milli_carry();
    send_item(make_stamp(2020, 6, 15, 12, 30, 58, 1023));
    send_item(make_stamp(2020, 6, 15, 12, 30, 59, 1000));
    send_item(make_stamp(2020, 6, 15, 12, 30, 0, 1000));
    send_item(make_stamp(2020, 6, 15, 12, 30, 59, 999));
  endtask

  task automatic test_random_stream(input int count);
    repeat (count) send_item(random_stamp());
  endtask

  task automatic test_receiver_holdoff();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    stall_request = 80;
    repeat (40) send_item(random_stamp());
    send_idle_pct = saved_pct;
  endtask

  initial begin
    send_idle_pct = 32;
    recv_idle_pct = 58;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_field_extremes();
    test_status_codes();
    test_milli_carry();
    test_random_stream(540);
    send_idle_pct = 58;
    recv_idle_pct = 32;
    test_random_stream(540);
    test_receiver_holdoff();
    wait_results_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(540);
    wait_results_drained();
    repeat (16) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
